[rtl/grbf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// Package for the Gaussian RBF feature encoder: field widths, job types,
// grid select codes and the 2^(-k/16) table. No dependencies.
package grbf_pkg;

    localparam int NUM_ACTIONS   = 3;
    localparam int BLOCK_SIZE    = 10;
    localparam int IDX_W         = 5;
    localparam int IN_W          = 16;
    localparam int SPACING_W     = 15;
    localparam int VAL_W         = 16;
    localparam int CNT_W         = 4;

    localparam logic [CNT_W-1:0] CNT_LAST   = CNT_W'(BLOCK_SIZE - 1);
    localparam logic [16:0]      LOG2E_Q16  = 17'd94548;
    localparam logic [VAL_W-1:0] ONE_Q15    = 16'd32768;

    localparam logic [1:0] SEL_NEG  = 2'd0;
    localparam logic [1:0] SEL_ZERO = 2'd1;
    localparam logic [1:0] SEL_POS  = 2'd2;

    localparam logic       CFG_POS_SPACING = 1'b0;
    localparam logic       CFG_SPD_SPACING = 1'b1;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             bias;
        logic             last;
    } t_meta;

    typedef struct packed {
        t_meta                   meta;
        logic signed [IN_W-1:0]  pos;
        logic signed [IN_W-1:0]  spd;
        logic [1:0]              psel;
        logic [1:0]              vsel;
    } t_job;

    // 2^(-k/16) in Q1.16, k = 0..16
    function automatic logic [16:0] f_pow2_neg(input logic [4:0] k);
        logic [16:0] t;
        case (k)
            5'd0:    t = 17'd65536;
            5'd1:    t = 17'd62757;
            5'd2:    t = 17'd60097;
            5'd3:    t = 17'd57549;
            5'd4:    t = 17'd55109;
            5'd5:    t = 17'd52773;
            5'd6:    t = 17'd50535;
            5'd7:    t = 17'd48393;
            5'd8:    t = 17'd46341;
            5'd9:    t = 17'd44376;
            5'd10:   t = 17'd42494;
            5'd11:   t = 17'd40693;
            5'd12:   t = 17'd38968;
            5'd13:   t = 17'd37316;
            5'd14:   t = 17'd35734;
            5'd15:   t = 17'd34219;
            default: t = 17'd32768;
        endcase
        return t;
    endfunction

    // grid point of entry cnt (1..9): {position select, speed select}
    function automatic logic [3:0] f_grid(input logic [CNT_W-1:0] cnt);
        logic [3:0] g;
        case (cnt)
            4'd1:    g = {SEL_NEG,  SEL_NEG};
            4'd2:    g = {SEL_NEG,  SEL_ZERO};
            4'd3:    g = {SEL_NEG,  SEL_POS};
            4'd4:    g = {SEL_ZERO, SEL_NEG};
            4'd5:    g = {SEL_ZERO, SEL_ZERO};
            4'd6:    g = {SEL_ZERO, SEL_POS};
            4'd7:    g = {SEL_POS,  SEL_NEG};
            4'd8:    g = {SEL_POS,  SEL_ZERO};
            4'd9:    g = {SEL_POS,  SEL_POS};
            default: g = {SEL_ZERO, SEL_ZERO};
        endcase
        return g;
    endfunction

endpackage
`default_nettype wire

[rtl/gaussian_rbf_feature_encoder_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Top level of the Gaussian RBF feature encoder: config registers,
// sequencer, distance and exponential pipelines. Depends on grbf_pkg.
//
// Each accepted item yields ten result transfers (bias, then the 3x3 grid,
// position center outer, speed center inner), one per cycle while
// i_out_ready is high; the next item is taken as the last job issues,
// a pace set by the single result channel. An item whose action is 3 or
// more yields no results and is taken without issuing jobs. The first
// result follows the input transfer through the sequencer register and
// six pipeline stages that stall cleanly on i_out_ready.
module gaussian_rbf_feature_encoder_core (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_cfg_we,
    input  wire logic                                   i_cfg_index,
    input  wire logic [grbf_pkg::SPACING_W-1:0]         i_cfg_data,
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_ready,
    input  wire logic signed [grbf_pkg::IN_W-1:0]       i_position,
    input  wire logic signed [grbf_pkg::IN_W-1:0]       i_speed,
    input  wire logic [1:0]                             i_action,
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_ready,
    output logic [grbf_pkg::IDX_W-1:0]                  o_feature_index,
    output logic [grbf_pkg::VAL_W-1:0]                  o_feature_value,
    output logic                                        o_last
);

    logic [grbf_pkg::SPACING_W-1:0] r_pos_spacing, r_spd_spacing;
    logic                           w_job_valid, w_job_ready;
    grbf_pkg::t_job                 w_job;
    logic                           w_d_valid, w_d_ready;
    grbf_pkg::t_meta                w_d_meta;
    logic [23:0]                    w_d_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_spacing <= 15'd3217;
            r_spd_spacing <= 15'd4096;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                grbf_pkg::CFG_POS_SPACING: r_pos_spacing <= i_cfg_data;
                grbf_pkg::CFG_SPD_SPACING: r_spd_spacing <= i_cfg_data;
                default: ;
            endcase
        end
    end

    grbf_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_position  (i_position),
        .i_speed     (i_speed),
        .i_action    (i_action),
        .o_job_valid (w_job_valid),
        .i_job_ready (w_job_ready),
        .o_job       (w_job)
    );

    grbf_dist u_dist (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pos_spacing (r_pos_spacing),
        .i_spd_spacing (r_spd_spacing),
        .i_job_valid   (w_job_valid),
        .o_job_ready   (w_job_ready),
        .i_job         (w_job),
        .o_valid       (w_d_valid),
        .i_ready       (w_d_ready),
        .o_meta        (w_d_meta),
        .o_x           (w_d_x)
    );

    grbf_exp u_exp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (w_d_valid),
        .o_ready         (w_d_ready),
        .i_meta          (w_d_meta),
        .i_x             (w_d_x),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_feature_index (o_feature_index),
        .o_feature_value (o_feature_value),
        .o_last          (o_last)
    );

endmodule
`default_nettype wire

[rtl/grbf_seq.sv]
`timescale 1ns / 1ps
`default_nettype none
// Job sequencer: captures one input item and issues its ten feature jobs,
// one per cycle while i_job_ready is high. Depends on grbf_pkg.
module grbf_seq (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic signed [grbf_pkg::IN_W-1:0] i_position,
    input  wire logic signed [grbf_pkg::IN_W-1:0] i_speed,
    input  wire logic [1:0]                      i_action,
    output logic                                 o_job_valid,
    input  wire logic                            i_job_ready,
    output grbf_pkg::t_job                       o_job
);

    logic                                  r_busy, n_busy;
    logic [grbf_pkg::CNT_W-1:0]            r_cnt, n_cnt;
    logic signed [grbf_pkg::IN_W-1:0]      r_pos, r_spd;
    logic [grbf_pkg::IDX_W-1:0]            r_base;
    logic                                  w_job_fire, w_accept, w_last;
    logic [3:0]                            w_grid;

    assign w_last      = (r_cnt == grbf_pkg::CNT_LAST);
    assign w_job_fire  = r_busy && i_job_ready;
    assign o_in_ready  = !r_busy || (i_job_ready && w_last);
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_job_valid = r_busy;
    assign w_grid      = grbf_pkg::f_grid(r_cnt);

    always_comb begin
        o_job.meta.idx  = r_base + grbf_pkg::IDX_W'(r_cnt);
        o_job.meta.bias = (r_cnt == '0);
        o_job.meta.last = w_last;
        o_job.pos       = r_pos;
        o_job.spd       = r_spd;
        o_job.psel      = w_grid[3:2];
        o_job.vsel      = w_grid[1:0];
    end

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        if (w_job_fire) begin
            n_cnt = r_cnt + 1'b1;
            if (w_last) begin
                n_busy = 1'b0;
            end
        end
        if (w_accept) begin
            n_busy = (32'(i_action) < grbf_pkg::NUM_ACTIONS);
            n_cnt  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pos  <= i_position;
            r_spd  <= i_speed;
            r_base <= grbf_pkg::IDX_W'(i_action * grbf_pkg::BLOCK_SIZE);
        end
    end

endmodule
`default_nettype wire

[rtl/grbf_dist.sv]
`timescale 1ns / 1ps
`default_nettype none
// Squared distance pipeline: center offset and magnitude, two squares,
// sum and halving. Three register stages. Depends on grbf_pkg.
module grbf_dist (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic [grbf_pkg::SPACING_W-1:0]       i_pos_spacing,
    input  wire logic [grbf_pkg::SPACING_W-1:0]       i_spd_spacing,
    input  wire logic                                 i_job_valid,
    output logic                                      o_job_ready,
    input  wire grbf_pkg::t_job                       i_job,
    output logic                                      o_valid,
    input  wire logic                                 i_ready,
    output grbf_pkg::t_meta                           o_meta,
    output logic [23:0]                               o_x
);

    logic                  r_va, r_vb, r_vc;
    logic                  w_ena, w_enb, w_enc;
    grbf_pkg::t_meta       r_meta_a, r_meta_b, r_meta_c;
    logic [15:0]           r_adp, r_adv;
    logic [31:0]           r_sqp, r_sqv;
    logic [23:0]           r_x;
    logic signed [17:0]    w_cp, w_cv, w_dp, w_dv;
    logic [32:0]           w_s;

    assign w_enc       = !r_vc || i_ready;
    assign w_enb       = !r_vb || w_enc;
    assign w_ena       = !r_va || w_enb;
    assign o_job_ready = w_ena;

    function automatic logic signed [17:0] f_center(input logic [1:0] sel,
                                                    input logic [14:0] sp);
        logic signed [17:0] c;
        case (sel)
            grbf_pkg::SEL_NEG: c = -$signed({3'b000, sp});
            grbf_pkg::SEL_POS: c = $signed({3'b000, sp});
            default:           c = '0;
        endcase
        return c;
    endfunction

    always_comb begin
        w_cp = f_center(i_job.psel, i_pos_spacing);
        w_cv = f_center(i_job.vsel, i_spd_spacing);
        w_dp = 18'(i_job.pos) - w_cp;
        w_dv = 18'(i_job.spd) - w_cv;
        w_s  = 33'(r_sqp) + 33'(r_sqv);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            if (w_ena) r_va <= i_job_valid;
            if (w_enb) r_vb <= r_va;
            if (w_enc) r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ena) begin
            r_meta_a <= i_job.meta;
            r_adp    <= w_dp[17] ? 16'(-w_dp) : w_dp[15:0];
            r_adv    <= w_dv[17] ? 16'(-w_dv) : w_dv[15:0];
        end
        if (w_enb) begin
            r_meta_b <= r_meta_a;
            r_sqp    <= 32'(r_adp) * 32'(r_adp);
            r_sqv    <= 32'(r_adv) * 32'(r_adv);
        end
        if (w_enc) begin
            r_meta_c <= r_meta_b;
            r_x      <= w_s[32:9];
        end
    end

    assign o_valid = r_vc;
    assign o_meta  = r_meta_c;
    assign o_x     = r_x;

endmodule
`default_nettype wire

[rtl/grbf_exp.sv]
`timescale 1ns / 1ps
`default_nettype none
// Exponential pipeline: scale by log2(e), table interpolation of the
// fraction, rounded shift by the integer part. Last stage is the output
// register; it forces bias entries to one and large inputs to zero. Depends on grbf_pkg.
module grbf_exp (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire grbf_pkg::t_meta                 i_meta,
    input  wire logic [23:0]                     i_x,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [grbf_pkg::IDX_W-1:0]           o_feature_index,
    output logic [grbf_pkg::VAL_W-1:0]           o_feature_value,
    output logic                                 o_last
);

    logic                  r_vd, r_ve, r_vf;
    logic                  w_end, w_ene, w_enf;
    grbf_pkg::t_meta       r_meta_d, r_meta_e, r_meta_f;
    logic [40:0]           w_y;
    logic                  r_sat_d, r_sat_e;
    logic [3:0]            r_n_d, r_n_e;
    logic [15:0]           r_f;
    logic [16:0]           w_t0, w_t1, r_t0;
    logic [23:0]           r_prod;
    logic [16:0]           w_m;
    logic [17:0]           w_sum, w_val;
    logic [grbf_pkg::VAL_W-1:0] r_val;

    assign w_enf   = !r_vf || i_out_ready;
    assign w_ene   = !r_ve || w_enf;
    assign w_end   = !r_vd || w_ene;
    assign o_ready = w_end;

    always_comb begin
        w_y   = 41'(i_x) * 41'(grbf_pkg::LOG2E_Q16);
        w_t0  = grbf_pkg::f_pow2_neg({1'b0, r_f[15:12]});
        w_t1  = grbf_pkg::f_pow2_neg(5'({1'b0, r_f[15:12]} + 5'd1));
        w_m   = r_t0 - 17'((r_prod + 24'd2048) >> 12);
        w_sum = 18'(w_m) + (18'd1 << r_n_e);
        w_val = w_sum >> (5'(r_n_e) + 5'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd <= 1'b0;
            r_ve <= 1'b0;
            r_vf <= 1'b0;
        end else begin
            if (w_end) r_vd <= i_valid;
            if (w_ene) r_ve <= r_vd;
            if (w_enf) r_vf <= r_ve;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_end) begin
            r_meta_d <= i_meta;
            r_sat_d  <= (w_y[40:32] >= 9'd16);
            r_n_d    <= w_y[35:32];
            r_f      <= w_y[31:16];
        end
        if (w_ene) begin
            r_meta_e <= r_meta_d;
            r_sat_e  <= r_sat_d;
            r_n_e    <= r_n_d;
            r_t0     <= w_t0;
            r_prod   <= 24'(w_t0 - w_t1) * 24'(r_f[11:0]);
        end
        if (w_enf) begin
            r_meta_f <= r_meta_e;
            if (r_meta_e.bias) begin
                r_val <= grbf_pkg::ONE_Q15;
            end else if (r_sat_e) begin
                r_val <= '0;
            end else begin
                r_val <= w_val[15:0];
            end
        end
    end

    assign o_out_valid     = r_vf;
    assign o_feature_index = r_meta_f.idx;
    assign o_feature_value = r_val;
    assign o_last          = r_meta_f.last;

endmodule
`default_nettype wire

[rtl/grbf_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// Port-level checker for the Gaussian RBF feature encoder and its bind.
// Depends on grbf_pkg.
module grbf_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          o_out_valid,
    input  wire logic                          i_out_ready,
    input  wire logic [grbf_pkg::IDX_W-1:0]    o_feature_index,
    input  wire logic [grbf_pkg::VAL_W-1:0]    o_feature_value,
    input  wire logic                          o_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_feature_index))
        else $error("result dropped or changed under stall");

    a_val_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_feature_value <= grbf_pkg::ONE_Q15)
        else $error("feature value above 1.0");

    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_last == (o_feature_index == 5'd9 ||
                                   o_feature_index == 5'd19 ||
                                   o_feature_index == 5'd29))
        else $error("last flag on wrong entry");

    a_bias: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_feature_index == 5'd0 || o_feature_index == 5'd10 ||
                        o_feature_index == 5'd20) |-> o_feature_value == grbf_pkg::ONE_Q15)
        else $error("bias entry not 1.0");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind gaussian_rbf_feature_encoder_core grbf_checker u_grbf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_feature_index (o_feature_index),
    .o_feature_value (o_feature_value),
    .o_last          (o_last)
);
`default_nettype wire

[sim/gaussian_rbf_feature_encoder_core_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for gaussian_rbf_feature_encoder_core: predicts the ten
// sparse RBF features per state-action transfer (none for action 3) and compares every output
// transfer in order. Depends on grbf_pkg and the core RTL.
module gaussian_rbf_feature_encoder_core_test;

    localparam int          CLK_HI     = 6;
    localparam int          CLK_LO     = 6;
    localparam int          RST_CYCLES = 10;
    localparam int          DRAIN      = 24;
    localparam int          LONG_HOLD  = 90;
    localparam int          CYCLE_MAX  = 250000;
    localparam int          N_PHASES   = 7;
    localparam int          PHASE_ITEMS = 60;
    localparam longint      LOG2E      = 94548;

    typedef struct packed {
        logic [grbf_pkg::IDX_W-1:0] idx;
        logic [grbf_pkg::VAL_W-1:0] val;
        logic                       last;
    } t_feature;

    class t_rbf_feature_board;
        t_feature    feature_q[$];
        int unsigned pow2_tab[17];
        int unsigned pos_spacing;
        int unsigned spd_spacing;
        int          errors;
        int          items;
        int          skipped_items;
        int          results;

        function new();
            pow2_tab = '{65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393,
                         46341, 44376, 42494, 40693, 38968, 37316, 35734, 34219,
                         32768};
            pos_spacing = 3217;
            spd_spacing = 4096;
        endfunction

        function void set_spacing(logic index, logic [grbf_pkg::SPACING_W-1:0] value);
            if (index == grbf_pkg::CFG_POS_SPACING)
                pos_spacing = value;
            else
                spd_spacing = value;
        endfunction

        // exp(-s/2), s in Q9.24, result in Q1.15
        function logic [grbf_pkg::VAL_W-1:0] gauss(longint unsigned s);
            longint unsigned x;
            longint unsigned y;
            longint unsigned n;
            int unsigned     f;
            int unsigned     k;
            int unsigned     fr;
            int unsigned     m;
            x = s >> 9;
            y = (x * LOG2E) >> 16;
            n = y >> 16;
            if (n >= 16)
                return '0;
            f  = int'(y & 64'hFFFF);
            k  = f >> 12;
            fr = f & 32'hFFF;
            m  = pow2_tab[k] - (((pow2_tab[k] - pow2_tab[k+1]) * fr + 2048) >> 12);
            return grbf_pkg::VAL_W'((m + (32'd1 << n)) >> (n + 1));
        endfunction

        function void predict_features(logic signed [grbf_pkg::IN_W-1:0] p,
                                       logic signed [grbf_pkg::IN_W-1:0] v,
                                       logic [1:0] act);
            longint   dp;
            longint   dv;
            longint   ci;
            longint   cj;
            int       base;
            int       k;
            t_feature e;
            items++;
            if (act >= grbf_pkg::NUM_ACTIONS) begin
                skipped_items++;
                return;
            end
            base = act * grbf_pkg::BLOCK_SIZE;
            e.idx  = grbf_pkg::IDX_W'(base);
            e.val  = grbf_pkg::ONE_Q15;
            e.last = 1'b0;
            feature_q.push_back(e);
            k = 1;
            for (int i = -1; i <= 1; i++) begin
                ci = longint'(i) * longint'(pos_spacing);
                dp = longint'(p) - ci;
                for (int j = -1; j <= 1; j++) begin
                    cj = longint'(j) * longint'(spd_spacing);
                    dv = longint'(v) - cj;
                    e.idx  = grbf_pkg::IDX_W'(base + k);
                    e.val  = gauss(longint'(dp * dp + dv * dv));
                    e.last = (k == grbf_pkg::BLOCK_SIZE - 1);
                    feature_q.push_back(e);
                    k++;
                end
            end
        endfunction

        function void check_feature(logic [grbf_pkg::IDX_W-1:0] idx,
                                    logic [grbf_pkg::VAL_W-1:0] val,
                                    logic last);
            t_feature e;
            results++;
            if (feature_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected transfer: index %0d value %0d last %0d",
                         $time, idx, val, last);
                return;
            end
            e = feature_q.pop_front();
            if (idx !== e.idx) begin
                errors++;
                $display("%0t: feature_index expected %0d actual %0d", $time, e.idx, idx);
            end
            if (val !== e.val) begin
                errors++;
                $display("%0t: feature_value (index %0d) expected %0d actual %0d",
                         $time, e.idx, e.val, val);
            end
            if (last !== e.last) begin
                errors++;
                $display("%0t: last (index %0d) expected %0d actual %0d",
                         $time, e.idx, e.last, last);
            end
        endfunction
    endclass

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_cfg_we;
    logic                             i_cfg_index;
    logic [grbf_pkg::SPACING_W-1:0]   i_cfg_data;
    logic                             i_in_valid;
    logic                             o_in_ready;
    logic signed [grbf_pkg::IN_W-1:0] i_position;
    logic signed [grbf_pkg::IN_W-1:0] i_speed;
    logic [1:0]                       i_action;
    logic                             o_out_valid;
    logic                             i_out_ready;
    logic [grbf_pkg::IDX_W-1:0]       o_feature_index;
    logic [grbf_pkg::VAL_W-1:0]       o_feature_value;
    logic                             o_last;

    t_rbf_feature_board board;
    int                 cycle_cnt;
    int                 settings_cnt;
    bit                 calm;
    bit                 long_hold;

    gaussian_rbf_feature_encoder_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_position      (i_position),
        .i_speed         (i_speed),
        .i_action        (i_action),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_feature_index (o_feature_index),
        .o_feature_value (o_feature_value),
        .o_last          (o_last)
    );

    initial begin
        board = new();
        i_clk = 1'b0;
    end

    always begin
        #CLK_LO i_clk = 1'b1;
        #CLK_HI i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_MAX) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we)
                board.set_spacing(i_cfg_index, i_cfg_data);
            if (i_in_valid && o_in_ready)
                board.predict_features(i_position, i_speed, i_action);
            if (o_out_valid && i_out_ready)
                board.check_feature(o_feature_index, o_feature_value, o_last);
        end
    end

    // result side: random stall bursts, one long hold on request
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                i_out_ready = 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
                long_hold = 1'b0;
            end else if (!calm && i_rst_n && $urandom_range(0, 4) == 0) begin
                i_out_ready = 1'b0;
                repeat ($urandom_range(0, 3)) @(negedge i_clk);
            end else begin
                i_out_ready = 1'b1;
            end
        end
    end

    task automatic send_item(logic signed [grbf_pkg::IN_W-1:0] p,
                             logic signed [grbf_pkg::IN_W-1:0] v,
                             logic [1:0] act);
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_position = p;
        i_speed    = v;
        i_action   = act;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
    endtask

    task automatic write_spacing(logic index, logic [grbf_pkg::SPACING_W-1:0] value);
        @(negedge i_clk);
        i_in_valid  = 1'b0;
        i_cfg_we    = 1'b1;
        i_cfg_index = index;
        i_cfg_data  = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (board.feature_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    function automatic logic signed [grbf_pkg::IN_W-1:0] clamp16(int val);
        if (val > 32767)
            return 16'sd32767;
        if (val < -32768)
            return -16'sd32768;
        return grbf_pkg::IN_W'(val);
    endfunction

    function automatic logic signed [grbf_pkg::IN_W-1:0] pick_coord(int unsigned spacing);
        int sel;
        sel = $urandom_range(0, 3);
        if (sel == 0)
            return grbf_pkg::IN_W'($urandom);
        if (sel == 3)
            return clamp16(($urandom_range(0, 2) - 1) * int'(spacing)
                           + $urandom_range(0, 1024) - 512);
        return clamp16($urandom_range(0, 16384) - 8192);
    endfunction

    task automatic random_items(int count);
        logic [1:0] act;
        for (int n = 0; n < count; n++) begin
            act = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
            send_item(pick_coord(board.pos_spacing), pick_coord(board.spd_spacing), act);
        end
    endtask

    initial begin
        int unsigned pos_set[N_PHASES];
        int unsigned spd_set[N_PHASES];
        pos_set = '{3217, 0, 32767, 0, 32767, 0, 3217};
        spd_set = '{4096, 0, 32767, 32767, 0, 0, 4096};
        pos_set[5] = $urandom_range(0, 32767);
        spd_set[5] = $urandom_range(0, 32767);
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = grbf_pkg::CFG_POS_SPACING;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_position  = '0;
        i_speed     = '0;
        i_action    = 2'd0;
        calm        = 1'b0;
        long_hold   = 1'b0;
        repeat (RST_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed, reset spacings
        send_item(16'sd0, 16'sd0, 2'd0);
        send_item(16'sd32767, 16'sd32767, 2'd1);
        send_item(-16'sd32768, -16'sd32768, 2'd2);
        send_item(16'sd32767, -16'sd32768, 2'd0);
        send_item(-16'sd32768, 16'sd32767, 2'd1);
        send_item(16'sd3217, 16'sd4096, 2'd2);
        send_item(-16'sd3217, -16'sd4096, 2'd0);
        send_item(16'sd0, 16'sd0, 2'd3);
        send_item(16'sd32767, 16'sd32767, 2'd3);
        send_item(16'sd1, -16'sd1, 2'd1);
        send_item(16'sh5555, -16'sh5556, 2'd2);
        send_item(-16'sd1, -16'sd1, 2'd0);
        send_item(16'sd8192, 16'sd0, 2'd1);
        send_item(16'sd0, -16'sd12000, 2'd2);
        send_item(16'sd20000, 16'sd20000, 2'd0);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain();
            write_spacing(grbf_pkg::CFG_POS_SPACING, grbf_pkg::SPACING_W'(pos_set[ph]));
            write_spacing(grbf_pkg::CFG_SPD_SPACING, grbf_pkg::SPACING_W'(spd_set[ph]));
            settings_cnt++;
            calm = (ph == N_PHASES - 1);
            if (ph == 1) begin
                long_hold = 1'b1;
                random_items(12);
                random_items(PHASE_ITEMS - 12);
            end else begin
                random_items(PHASE_ITEMS);
            end
        end
        drain();

        $display("covered %0d transfers in (%0d with no feature block), %0d features out,",
                 board.items, board.skipped_items, board.results);
        $display("over %0d spacing settings plus reset values", settings_cnt);
        if (board.errors == 0 && board.feature_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
